// ----- hw/rtl/rmq2d_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq2d_pkg: shared types and constants
// Sizes, payload structs and codes for the 2-D range-minimum block.
// ----------------------------------------------------------------------------
package rmq2d_pkg;

   localparam int MaxRows    = 64;
   localparam int MaxCols    = 64;
   localparam int RowLevels  = 7;
   localparam int ColLevels  = 7;
   localparam int ValueWidth = 32;

   localparam int RowBits  = 6;
   localparam int ColBits  = 6;
   localparam int LvlBits  = 3;
   localparam int CellAddrBits = RowBits + ColBits;
   localparam int CellDepth    = MaxRows * MaxCols;
   localparam int TabDepth     = ColLevels * RowLevels * MaxRows * MaxCols;
   localparam int TabAddrBits  = $clog2(TabDepth);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_BUILD = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RECT  = 2'd1,
      ST_NOT_BUILT = 2'd2,
      ST_BUILT     = 2'd3
   } status_type;

   localparam logic [0:0] CSR_ROWS = 1'b0;
   localparam logic [0:0] CSR_COLS = 1'b1;

   typedef struct packed {
      logic [1:0]                   kind;
      logic [5:0]                   row_start;
      logic [5:0]                   col_start;
      logic [5:0]                   row_end;
      logic [5:0]                   col_end;
      logic signed [ValueWidth-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] minimum;
      logic [1:0]                   status;
   } rsp_type;

   // floor(log2(v)) for v in 1..64
   function automatic logic [LvlBits-1:0] flog2(input logic [6:0] v);
      logic [LvlBits-1:0] l;
      l = '0;
      for (int i = 1; i < 7; i++) begin
         if (v[i]) begin
            l = LvlBits'(i);
         end
      end
      return l;
   endfunction

   function automatic logic [TabAddrBits-1:0] tab_addr(
      input logic [LvlBits-1:0] lc, input logic [LvlBits-1:0] lr,
      input logic [RowBits-1:0] r, input logic [ColBits-1:0] c);
      logic [TabAddrBits-1:0] blk;
      blk = TabAddrBits'(lc) * TabAddrBits'(RowLevels) + TabAddrBits'(lr);
      return TabAddrBits'({blk, r, c});
   endfunction

endpackage

// ----- hw/rtl/rmq2d_ram.sv -----
// ----------------------------------------------------------------------------
// rmq2d_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module rmq2d_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- hw/rtl/range_min_query_2d.sv -----
// ----------------------------------------------------------------------------
// range_min_query_2d: two-dimensional sparse-table rectangle minimum
// Cell writes land in a 4096-word cell RAM; a build fills a single-port table
// RAM level by level; a query reads four table words and returns their min.
// ----------------------------------------------------------------------------
// One item at a time. A query issues four reads of the single-port table
// RAM back to back, each word coming from its registered read port, then
// folds the last word in while the response is registered.
// A build walks the table RAM one word per read/compare/write: copying the
// level-0 cells reads each cell and then writes it to the table, and each
// higher column or row level reads two entries and writes their minimum
// for each entry produced. A result waits in the output register; the next
// item is taken once it is gone. Configuration writes are taken only while
// the block is idle with no response waiting, and clear the built mark.
// ----------------------------------------------------------------------------
module range_min_query_2d (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rmq2d_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rmq2d_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [6:0]          csr_wdata
);

   localparam int AW = rmq2d_pkg::TabAddrBits;
   localparam int VW = rmq2d_pkg::ValueWidth;
   localparam int LB = rmq2d_pkg::LvlBits;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CRD   = 9'b000000010, // copy: read cell
      S_CWR   = 9'b000000100, // copy: write table
      S_RA    = 9'b000001000, // level: read first half
      S_RB    = 9'b000010000, // level: read second half
      S_WR    = 9'b000100000, // level: write min
      S_Q     = 9'b001000000, // query reads
      S_QEND  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] rows_ff, rows_in, cols_ff, cols_in;
   logic built_ff, built_in;
   logic [LB-1:0] lc_ff, lc_in, lr_ff, lr_in;
   logic colpass_ff, colpass_in;      // 1 while building column levels
   logic [5:0] r_ff, r_in, c_ff, c_in;
   logic [VW-1:0] a_ff, a_in;
   logic [1:0] q_ff, q_in;            // query read counter
   logic qdone_ff, qdone_in;          // set once the first read word is in qmin
   logic [VW-1:0] qmin_ff, qmin_in;
   logic [LB-1:0] qlc_ff, qlc_in, qlr_ff, qlr_in;
   logic [5:0] qr1_ff, qr1_in, qc1_ff, qc1_in, qr2_ff, qr2_in, qc2_ff, qc2_in;
   logic rsp_valid_ff, rsp_valid_in;
   rmq2d_pkg::rsp_type rsp_ff, rsp_in;

   logic cell_we, tab_we;
   logic [rmq2d_pkg::CellAddrBits-1:0] cell_addr;
   logic [AW-1:0] tab_addr;
   logic [VW-1:0] cell_rd, tab_rd, tab_wd;

   rmq2d_ram #(.Width(VW), .Depth(rmq2d_pkg::CellDepth)) u_cells (
      .clock(clock), .wr_en(cell_we), .addr(cell_addr),
      .wr_data(req_data.cell_value), .rd_data(cell_rd));
   rmq2d_ram #(.Width(VW), .Depth(rmq2d_pkg::TabDepth)) u_table (
      .clock(clock), .wr_en(tab_we), .addr(tab_addr),
      .wr_data(tab_wd), .rd_data(tab_rd));

   // clamp used area to 1..64
   logic [6:0] n_used, m_used;
   assign n_used = (rows_ff == 7'd0) ? 7'd1 : ((rows_ff > 7'd64) ? 7'd64 : rows_ff);
   assign m_used = (cols_ff == 7'd0) ? 7'd1 : ((cols_ff > 7'd64) ? 7'd64 : cols_ff);

   function automatic logic [VW-1:0] smin(input logic [VW-1:0] x, input logic [VW-1:0] y);
      return ($signed(x) < $signed(y)) ? x : y;
   endfunction

   // level geometry of the current build pass
   logic [7:0] span, lim_r, lim_c;
   logic [5:0] half;
   always_comb begin
      span  = colpass_ff ? (8'd1 << lc_ff) : (8'd1 << lr_ff);
      half  = colpass_ff ? 6'(span >> 1) : 6'(span >> 1);
      lim_r = colpass_ff ? {1'b0, n_used} : {1'b0, n_used} - (8'd1 << lr_ff) + 8'd1;
      lim_c = {1'b0, m_used} - (8'd1 << lc_ff) + 8'd1;
   end

   // next level after finishing one
   logic [LB-1:0] nlc, nlr;
   logic ncol, nfin;
   always_comb begin
      nlc = lc_ff; nlr = lr_ff; ncol = colpass_ff; nfin = 1'b0;
      if (colpass_ff) begin
         nlc = lc_ff + 1'b1;
         if (!(nlc < LB'(rmq2d_pkg::ColLevels) && ((8'd1 << nlc) <= {1'b0, m_used}))) begin
            ncol = 1'b0; nlc = '0; nlr = LB'(1);
         end
      end else begin
         nlr = lr_ff + 1'b1;
         if (!(nlr < LB'(rmq2d_pkg::RowLevels) && ((8'd1 << nlr) <= {1'b0, n_used}))) begin
            nlr = LB'(1); nlc = lc_ff + 1'b1;
            if (!(nlc < LB'(rmq2d_pkg::ColLevels) && ((8'd1 << nlc) <= {1'b0, m_used}))) begin
               nfin = 1'b1;
            end
         end
      end
      if (ncol == 1'b0 && !nfin
          && !(nlr < LB'(rmq2d_pkg::RowLevels) && ((8'd1 << nlr) <= {1'b0, n_used}))) begin
         nfin = 1'b1; // single-row matrix: no row levels
      end
   end

   // query decode
   logic [6:0] qh, qw;
   logic [LB-1:0] dlr, dlc;
   logic qbad;
   always_comb begin
      qh  = 7'(req_data.row_end) - 7'(req_data.row_start) + 7'd1;
      qw  = 7'(req_data.col_end) - 7'(req_data.col_start) + 7'd1;
      dlr = rmq2d_pkg::flog2(qh);
      dlc = rmq2d_pkg::flog2(qw);
      qbad = (req_data.row_start > req_data.row_end) || (req_data.col_start > req_data.col_end)
          || (7'(req_data.row_end) >= n_used) || (7'(req_data.col_end) >= m_used);
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   // no CSR transfer while a build or query is in flight
   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   logic req_fire;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff; rows_in = rows_ff; cols_in = cols_ff; built_in = built_ff;
      lc_in = lc_ff; lr_in = lr_ff; colpass_in = colpass_ff; r_in = r_ff; c_in = c_ff;
      a_in = a_ff; q_in = q_ff; qdone_in = qdone_ff; qmin_in = qmin_ff;
      qlc_in = qlc_ff; qlr_in = qlr_ff; qr1_in = qr1_ff; qc1_in = qc1_ff;
      qr2_in = qr2_ff; qc2_in = qc2_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      cell_we = 1'b0; tab_we = 1'b0;
      cell_addr = {req_data.row_start, req_data.col_start};
      tab_addr = rmq2d_pkg::tab_addr('0, '0, r_ff, c_ff);
      tab_wd = a_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         built_in = 1'b0;
         unique case (csr_index)
            rmq2d_pkg::CSR_ROWS: rows_in = csr_wdata;
            rmq2d_pkg::CSR_COLS: cols_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (rmq2d_pkg::kind_type'(req_data.kind))
                  rmq2d_pkg::KIND_WRITE: begin
                     cell_we = 1'b1;
                     built_in = 1'b0;
                  end
                  rmq2d_pkg::KIND_BUILD: begin
                     r_in = '0; c_in = '0;
                     state_in = S_CRD;
                  end
                  rmq2d_pkg::KIND_QUERY: begin
                     rsp_in.minimum = '0;
                     if (!built_ff) begin
                        rsp_in.status = rmq2d_pkg::ST_NOT_BUILT;
                        rsp_valid_in = 1'b1;
                     end else if (qbad) begin
                        rsp_in.status = rmq2d_pkg::ST_BAD_RECT;
                        rsp_valid_in = 1'b1;
                     end else begin
                        qlr_in = dlr; qlc_in = dlc;
                        qr1_in = req_data.row_start; qc1_in = req_data.col_start;
                        qr2_in = 6'(7'(req_data.row_end) + 7'd1 - (7'd1 << dlr));
                        qc2_in = 6'(7'(req_data.col_end) + 7'd1 - (7'd1 << dlc));
                        q_in = '0; qdone_in = 1'b0;
                        state_in = S_Q;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CRD: begin
            cell_addr = {r_ff, c_ff};
            state_in = S_CWR;
         end
         S_CWR: begin
            tab_we = 1'b1;
            tab_wd = cell_rd;
            tab_addr = rmq2d_pkg::tab_addr('0, '0, r_ff, c_ff);
            state_in = S_CRD;
            if (7'(c_ff) + 7'd1 < m_used) begin
               c_in = c_ff + 1'b1;
            end else begin
               c_in = '0;
               if (7'(r_ff) + 7'd1 < n_used) begin
                  r_in = r_ff + 1'b1;
               end else begin
                  r_in = '0;
                  if (m_used >= 7'd2) begin
                     colpass_in = 1'b1; lc_in = LB'(1); lr_in = '0;
                     state_in = S_RA;
                  end else if (n_used >= 7'd2) begin
                     colpass_in = 1'b0; lc_in = '0; lr_in = LB'(1);
                     state_in = S_RA;
                  end else begin
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_RA: begin
            tab_addr = colpass_ff ? rmq2d_pkg::tab_addr(lc_ff - 1'b1, '0, r_ff, c_ff)
                                  : rmq2d_pkg::tab_addr(lc_ff, lr_ff - 1'b1, r_ff, c_ff);
            state_in = S_RB;
         end
         S_RB: begin
            a_in = tab_rd;
            tab_addr = colpass_ff ? rmq2d_pkg::tab_addr(lc_ff - 1'b1, '0, r_ff, c_ff + half)
                                  : rmq2d_pkg::tab_addr(lc_ff, lr_ff - 1'b1, r_ff + half, c_ff);
            state_in = S_WR;
         end
         S_WR: begin
            tab_we = 1'b1;
            tab_wd = smin(a_ff, tab_rd);
            tab_addr = rmq2d_pkg::tab_addr(lc_ff, lr_ff, r_ff, c_ff);
            state_in = S_RA;
            if (8'(c_ff) + 8'd1 < lim_c) begin
               c_in = c_ff + 1'b1;
            end else begin
               c_in = '0;
               if (8'(r_ff) + 8'd1 < lim_r) begin
                  r_in = r_ff + 1'b1;
               end else begin
                  r_in = '0;
                  lc_in = nlc; lr_in = nlr; colpass_in = ncol;
                  if (nfin) begin
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_Q: begin
            // read block q; data of block q-1 arrives now
            unique case (q_ff)
               2'd0: tab_addr = rmq2d_pkg::tab_addr(qlc_ff, qlr_ff, qr1_ff, qc1_ff);
               2'd1: tab_addr = rmq2d_pkg::tab_addr(qlc_ff, qlr_ff, qr2_ff, qc2_ff);
               2'd2: tab_addr = rmq2d_pkg::tab_addr(qlc_ff, qlr_ff, qr2_ff, qc1_ff);
               default: tab_addr = rmq2d_pkg::tab_addr(qlc_ff, qlr_ff, qr1_ff, qc2_ff);
            endcase
            if (qdone_ff) begin
               qmin_in = smin(qmin_ff, tab_rd);
            end else if (q_ff == 2'd1) begin
               qmin_in = tab_rd;
               qdone_in = 1'b1;
            end
            q_in = q_ff + 1'b1;
            if (q_ff == 2'd3) begin
               state_in = S_QEND;
            end
         end
         S_QEND: begin
            rsp_in.minimum = smin(qmin_ff, tab_rd);
            rsp_in.status = rmq2d_pkg::ST_OK;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_OUT: begin
            rsp_in.minimum = '0;
            rsp_in.status = rmq2d_pkg::ST_BUILT;
            rsp_valid_in = 1'b1;
            built_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= 7'd64;
         cols_ff <= 7'd64;
         built_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         colpass_ff <= 1'b0;
         lc_ff <= '0; lr_ff <= '0; r_ff <= '0; c_ff <= '0;
         q_ff <= '0; qdone_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         built_ff <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         colpass_ff <= colpass_in;
         lc_ff <= lc_in; lr_ff <= lr_in; r_ff <= r_in; c_ff <= c_in;
         q_ff <= q_in; qdone_ff <= qdone_in;
      end
      a_ff <= a_in; qmin_ff <= qmin_in;
      qlc_ff <= qlc_in; qlr_ff <= qlr_in;
      qr1_ff <= qr1_in; qc1_ff <= qc1_in; qr2_ff <= qr2_in; qc2_ff <= qc2_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("req_ready outside idle");
   a_ok_built: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == rmq2d_pkg::ST_OK |-> built_ff)
      else $error("ok answer without built tables");
   a_no_tab_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !tab_we)
      else $error("table write while idle");
`endif

endmodule
